// ----- src/dpst_pkg.sv -----
// ----------------------------------------------------------------------------
// dpst_pkg
// Shared types and constants of the debounced press switch timer.
// ----------------------------------------------------------------------------
package dpst_pkg;

  localparam int TIME_W   = 32;  // remaining time and press length counters
  localparam int DEB_W    = 16;  // debounce counter, same width as debounce_ms
  localparam int CFG_IW   = 3;   // configuration register index
  localparam int CFG_DW   = 32;  // configuration write data
  localparam int IN_DW    = 8;   // s_axis_tdata width
  localparam int IN_UW    = 2;   // s_axis_tuser width
  localparam int OUT_DW   = 40;  // m_axis_tdata width

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [DEB_W-1:0]  DEB_MAX  = '1;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_ON   = 2'd2,
    KIND_OFF  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TIMED = 2'd1,
    MODE_PERM  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2,
    EV_DEAD  = 2'd3
  } event_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_SHORT_MAX  = 3'd1,
    REG_LONG_MIN   = 3'd2,
    REG_CYCLE      = 3'd3,
    REG_BTN_LEVEL  = 3'd4,
    REG_RELAY_LVL  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ms;
    logic [TIME_W-1:0] short_press_max_ms;
    logic [TIME_W-1:0] long_press_min_ms;
    logic [TIME_W-1:0] cycle_ms;
    logic              button_active_level;
    logic              relay_active_level;
  } cfg_t;

  typedef struct packed {
    logic              relay_drive;
    mode_t             mode;
    logic [TIME_W-1:0] remaining_ms;
  } timer_out_t;

endpackage

// ----- src/debounced_press_switch_timer_core.sv -----
// ----------------------------------------------------------------------------
// debounced_press_switch_timer_core
// Relay countdown timer driven by a debounced push button and remote commands.
// ----------------------------------------------------------------------------
// Each input beat is either a one-millisecond tick carrying the button pin
// sample or a remote command (add time, force on, force off); commands do not
// advance time. Every beat yields exactly one output beat with the relay drive
// level, the mode (idle, timed, permanent), the remaining milliseconds and the
// button event decoded on that beat (start, stop, or an ignored dead-zone
// press). A beat is captured in an input register, resolved by the debounce
// and timer update logic, and held in an output register, so the block
// sustains one beat per clock while the consumer keeps m_axis_tready high;
// while the output register is stalled, the input register keeps its beat.
// The state update that each beat depends on is done before the next beat is
// resolved, so output back-pressure is the only limit on rate.
// Configuration is written through the cfg channel, which is always ready, and
// must only be written while no beat is in flight.
// ----------------------------------------------------------------------------
module debounced_press_switch_timer_core import dpst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  input  logic [IN_UW-1:0]  s_axis_tuser,   // [1:0] kind
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // [0] relay_drive, [2:1] mode,
                                            // [34:3] remaining_ms,
                                            // [36:35] button_event, [39:37] zero
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t       cfg;
  logic       in_valid;
  kind_t      in_kind;
  logic       in_pin;
  logic       advance;
  event_t     button_event;
  timer_out_t timer_res;

  assign cfg_ready = 1'b1;

  // Move the held beat to the output whenever the output slot is free or drains.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Capture payload on acceptance only.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= kind_t'(s_axis_tuser[1:0]);
      in_pin  <= s_axis_tdata[0];
    end
  end

  dpst_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dpst_button u_button (
    .clk          (clk),
    .rst          (rst),
    .update       (advance),
    .is_tick      (in_kind == KIND_TICK),
    .pin_level    (in_pin),
    .cfg          (cfg),
    .button_event (button_event)
  );

  dpst_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .update       (advance),
    .kind         (in_kind),
    .button_event (button_event),
    .cfg          (cfg),
    .result       (timer_res)
  );

  // Output register: hold the beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {3'b000, button_event, timer_res.remaining_ms,
                       timer_res.mode, timer_res.relay_drive};
    end
  end

endmodule

// ----- src/dpst_cfg.sv -----
// ----------------------------------------------------------------------------
// dpst_cfg
// Configuration register file, written through an index/data channel.
// ----------------------------------------------------------------------------
module dpst_cfg import dpst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CFG_IW-1:0] wr_index,
  input  logic [CFG_DW-1:0] wr_data,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms         <= DEB_W'(50);
      cfg.short_press_max_ms  <= TIME_W'(1000);
      cfg.long_press_min_ms   <= TIME_W'(3000);
      cfg.cycle_ms            <= TIME_W'(60000);
      cfg.button_active_level <= 1'b0;
      cfg.relay_active_level  <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE:  cfg.debounce_ms         <= wr_data[DEB_W-1:0];
        REG_SHORT_MAX: cfg.short_press_max_ms  <= wr_data[TIME_W-1:0];
        REG_LONG_MIN:  cfg.long_press_min_ms   <= wr_data[TIME_W-1:0];
        REG_CYCLE:     cfg.cycle_ms            <= wr_data[TIME_W-1:0];
        REG_BTN_LEVEL: cfg.button_active_level <= wr_data[0];
        REG_RELAY_LVL: cfg.relay_active_level  <= wr_data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

// ----- src/dpst_button.sv -----
// ----------------------------------------------------------------------------
// dpst_button
// Button debounce and press-length classification, one tick per update.
// ----------------------------------------------------------------------------
module dpst_button import dpst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   update,     // commit state for the current item
  input  logic   is_tick,    // current item is a tick
  input  logic   pin_level,
  input  cfg_t   cfg,
  output event_t button_event
);

  logic              stable_level, stable_level_next;
  logic              debounce_busy, debounce_busy_next;
  logic              pending_level, pending_level_next;
  logic [DEB_W-1:0]  debounce_count, debounce_count_next;
  logic              press_held, press_held_next;
  logic [TIME_W-1:0] press_count, press_count_next;
  logic [TIME_W-1:0] press_len;
  logic [DEB_W-1:0]  deb_inc;
  event_t            ev;

  always_comb begin
    // advance press length first, saturating
    press_len = (press_held && press_count != TIME_MAX) ? press_count + 1'b1 : press_count;
    deb_inc   = (debounce_count != DEB_MAX) ? debounce_count + 1'b1 : debounce_count;

    stable_level_next   = stable_level;
    debounce_busy_next  = debounce_busy;
    pending_level_next  = pending_level;
    debounce_count_next = debounce_count;
    press_held_next     = press_held;
    press_count_next    = press_len;
    ev                  = EV_NONE;

    if (pin_level != stable_level && !debounce_busy) begin
      debounce_busy_next  = 1'b1;
      debounce_count_next = '0;
      pending_level_next  = pin_level;
    end else if (debounce_busy) begin
      debounce_count_next = deb_inc;
      if (deb_inc >= cfg.debounce_ms) begin
        debounce_busy_next = 1'b0;
        if (pin_level == pending_level) begin
          stable_level_next = pin_level;
          if (pin_level == cfg.button_active_level) begin
            press_held_next  = 1'b1;
            press_count_next = '0;
          end else if (press_held) begin
            press_held_next = 1'b0;
            priority if (press_len < cfg.short_press_max_ms) ev = EV_START;
            else if (press_len >= cfg.long_press_min_ms)    ev = EV_STOP;
            else                                             ev = EV_DEAD;
          end
        end
      end
    end

    button_event = is_tick ? ev : EV_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level   <= 1'b1;  // inverse of the reset active level
      debounce_busy  <= 1'b0;
      pending_level  <= 1'b0;
      debounce_count <= '0;
      press_held     <= 1'b0;
      press_count    <= '0;
    end else if (update && is_tick) begin
      stable_level   <= stable_level_next;
      debounce_busy  <= debounce_busy_next;
      pending_level  <= pending_level_next;
      debounce_count <= debounce_count_next;
      press_held     <= press_held_next;
      press_count    <= press_count_next;
    end
  end

endmodule

// ----- src/dpst_timer.sv -----
// ----------------------------------------------------------------------------
// dpst_timer
// Mode and remaining-time state with saturating add and countdown.
// ----------------------------------------------------------------------------
module dpst_timer import dpst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       update,
  input  kind_t      kind,
  input  event_t     button_event,
  input  cfg_t       cfg,
  output timer_out_t result
);

  mode_t             mode_reg, mode_next;
  logic [TIME_W-1:0] remaining_count, remaining_next;
  logic [TIME_W-1:0] rem_dec, add_base;
  logic [TIME_W:0]   add_sum;
  logic [TIME_W-1:0] add_sat;
  logic              do_add;

  always_comb begin
    rem_dec  = (remaining_count != '0) ? remaining_count - 1'b1 : remaining_count;
    add_base = (mode_reg == MODE_IDLE) ? '0 :
               (kind == KIND_TICK) ? rem_dec : remaining_count;
    add_sum  = {1'b0, add_base} + {1'b0, cfg.cycle_ms};
    add_sat  = add_sum[TIME_W] ? TIME_MAX : add_sum[TIME_W-1:0];

    mode_next      = mode_reg;
    remaining_next = remaining_count;
    do_add         = 1'b0;

    unique case (kind)
      KIND_TICK: begin
        remaining_next = rem_dec;
        if (button_event == EV_START) begin
          do_add = 1'b1;
        end else if (button_event == EV_STOP && mode_reg != MODE_IDLE) begin
          mode_next      = MODE_IDLE;
          remaining_next = '0;
        end
      end
      KIND_ADD: do_add = 1'b1;
      KIND_ON: begin
        mode_next      = MODE_PERM;
        remaining_next = '0;
      end
      KIND_OFF: begin
        mode_next      = MODE_IDLE;
        remaining_next = '0;
      end
      default: ;
    endcase

    // permanent mode ignores added time
    if (do_add && mode_reg != MODE_PERM) begin
      mode_next      = MODE_TIMED;
      remaining_next = add_sat;
    end

    if (kind == KIND_TICK && mode_next == MODE_TIMED && remaining_next == '0) begin
      mode_next = MODE_IDLE;
    end

    result.mode         = mode_next;
    result.relay_drive  = (mode_next != MODE_IDLE) ? cfg.relay_active_level
                                                   : ~cfg.relay_active_level;
    result.remaining_ms = (mode_next == MODE_TIMED) ? remaining_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_IDLE;
      remaining_count <= '0;
    end else if (update) begin
      mode_reg        <= mode_next;
      remaining_count <= remaining_next;
    end
  end

endmodule

// ----- src/dpst_checker.sv -----
// ----------------------------------------------------------------------------
// dpst_checker
// Port-level checks of the debounced press switch timer core.
// ----------------------------------------------------------------------------
module dpst_checker import dpst_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata
);

  // hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:1] != 2'd3)
    else $error("mode field out of range");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:1] != MODE_TIMED |-> m_axis_tdata[34:3] == '0)
    else $error("remaining time outside timed mode");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[36:35] == EV_STOP |-> m_axis_tdata[2:1] == MODE_IDLE)
    else $error("stop event did not leave the timer idle");

endmodule

bind debounced_press_switch_timer_core dpst_checker u_dpst_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/relay_timer_checker.sv -----
// ----------------------------------------------------------------------------
// relay_timer_checker
// Predicts and checks every status beat of the press switch timer core.
// ----------------------------------------------------------------------------
// Watches the cfg, input and status channels. It keeps its own copy of the
// registers and of the debounce, press and countdown state. For each accepted
// input beat it predicts one status beat, and it compares the status beats in
// order. It hands the error count and the number of beats in flight to the top.
// ----------------------------------------------------------------------------
module relay_timer_checker import dpst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,
  input  logic [IN_UW-1:0]  s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_DW-1:0] m_axis_tdata,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                error_count,
  output int                in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // Same layout as m_axis_tdata, relay_drive in bit 0.
  typedef struct packed {
    logic [2:0]        pad;
    event_t            ev;
    logic [TIME_W-1:0] left;
    mode_t             mode;
    logic              relay;
  } status_t;

  cfg_t              regs;
  mode_t             cur_mode;
  logic [TIME_W-1:0] time_left;
  logic              stable_lvl;
  logic              deb_busy;
  logic              pend_lvl;
  logic [DEB_W-1:0]  deb_cnt;
  logic              held;
  logic [TIME_W-1:0] press_len;
  status_t           status_q[$];

  function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic void extend_timer();
    if (cur_mode == MODE_IDLE) begin
      cur_mode  = MODE_TIMED;
      time_left = regs.cycle_ms;
    end else if (cur_mode == MODE_TIMED) begin
      time_left = sat_sum(time_left, regs.cycle_ms);
    end
  endfunction

  // Debounce one pin sample; return the press event it completes, if any.
  // debounce_ms has the counter's width, so it never needs clamping.
  function automatic event_t debounce_sample(logic pin);
    if (pin != stable_lvl && !deb_busy) begin
      deb_busy = 1'b1;
      deb_cnt  = '0;
      pend_lvl = pin;
      return EV_NONE;
    end
    if (!deb_busy) return EV_NONE;
    if (deb_cnt != DEB_MAX) deb_cnt++;
    if (deb_cnt < regs.debounce_ms) return EV_NONE;
    deb_busy = 1'b0;
    if (pin != pend_lvl) return EV_NONE;
    stable_lvl = pin;
    if (pin == regs.button_active_level) begin
      held      = 1'b1;
      press_len = '0;
      return EV_NONE;
    end
    if (!held) return EV_NONE;
    held = 1'b0;
    if (press_len < regs.short_press_max_ms) return EV_START;
    if (press_len >= regs.long_press_min_ms) return EV_STOP;
    return EV_DEAD;
  endfunction

  function automatic status_t predict_status(kind_t kind, logic pin);
    event_t  ev;
    status_t s;
    ev = EV_NONE;
    case (kind)
      KIND_TICK: begin
        if (time_left != 0) time_left--;
        if (held && press_len != TIME_MAX) press_len++;
        ev = debounce_sample(pin);
        if (ev == EV_START) begin
          if (cur_mode != MODE_PERM) extend_timer();
        end else if (ev == EV_STOP) begin
          cur_mode  = MODE_IDLE;
          time_left = '0;
        end
        if (cur_mode == MODE_TIMED && time_left == 0) cur_mode = MODE_IDLE;
      end
      KIND_ADD: extend_timer();
      KIND_ON: begin
        cur_mode  = MODE_PERM;
        time_left = '0;
      end
      default: begin
        cur_mode  = MODE_IDLE;
        time_left = '0;
      end
    endcase
    s.pad   = '0;
    s.ev    = ev;
    s.left  = (cur_mode == MODE_TIMED) ? time_left : '0;
    s.mode  = cur_mode;
    s.relay = (cur_mode != MODE_IDLE) ? regs.relay_active_level : ~regs.relay_active_level;
    return s;
  endfunction

  task automatic report(string what, status_t want, status_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: want relay=%0b mode=%0d left=%0d ev=%0d pad=%0d, got relay=%0b mode=%0d left=%0d ev=%0d pad=%0d",
               $realtime, what, want.relay, want.mode, want.left, want.ev, want.pad,
               got.relay, got.mode, got.left, got.ev, got.pad);
  endtask

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst) begin
      regs.debounce_ms         = 16'd50;
      regs.short_press_max_ms  = 32'd1000;
      regs.long_press_min_ms   = 32'd3000;
      regs.cycle_ms            = 32'd60000;
      regs.button_active_level = 1'b0;
      regs.relay_active_level  = 1'b1;
      cur_mode   = MODE_IDLE;
      time_left  = '0;
      stable_lvl = 1'b1;
      deb_busy   = 1'b0;
      pend_lvl   = 1'b0;
      deb_cnt    = '0;
      held       = 1'b0;
      press_len  = '0;
      status_q.delete();
      in_flight <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEBOUNCE:  regs.debounce_ms         = cfg_data[DEB_W-1:0];
          REG_SHORT_MAX: regs.short_press_max_ms  = cfg_data[TIME_W-1:0];
          REG_LONG_MIN:  regs.long_press_min_ms   = cfg_data[TIME_W-1:0];
          REG_CYCLE:     regs.cycle_ms            = cfg_data[TIME_W-1:0];
          REG_BTN_LEVEL: regs.button_active_level = cfg_data[0];
          REG_RELAY_LVL: regs.relay_active_level  = cfg_data[0];
          default: ;
        endcase
      end
      // Compare before predicting: a beat leaving now belongs to an older input.
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (status_q.size() == 0) begin
          report("unexpected status beat", '0, got);
        end else begin
          want = status_q.pop_front();
          if (got !== want) report("status mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        status_q.push_back(predict_status(kind_t'(s_axis_tuser), s_axis_tdata[0]));
      in_flight <= status_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the debounced press switch timer core.
// ----------------------------------------------------------------------------
// Drives ticks, button presses and remote commands into the core under several
// register settings, with random idle bursts on both streams, while
// relay_timer_checker predicts and checks every status beat.
// ----------------------------------------------------------------------------
module tb_top;
  import dpst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // All inputs of the core start at known values.
  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata  = '0;   // [0] pin_level
  logic [IN_UW-1:0]  s_axis_tuser  = '0;   // [1:0] kind
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;         // relay, mode, remaining, event
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index     = '0;
  logic [CFG_DW-1:0] cfg_data      = '0;

  int   error_count;
  int   in_flight;

  bit   stall_en   = 1'b1;  // random idle bursts on both streams
  int   stall_left = 0;
  int   beats_sent = 0;
  bit   leftover   = 1'b0;  // status beats still owed after a drain

  // Current setting, mirrored so that presses can be shaped around it.
  logic [15:0] set_deb;
  logic [31:0] set_smax;
  logic [31:0] set_lmin;
  logic        set_btn;

  always #2 clk = ~clk;

  debounced_press_switch_timer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  relay_timer_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .in_flight     (in_flight)
  );

  // Status side: drop tready for bursts of random length now and then.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_en && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Ready is sampled at the falling edge, where it is settled; the beat then
  // moves at the next rising edge. Valid stays high into the next call.
  task automatic send_beat(kind_t k, logic pin);
    if (stall_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {{(IN_DW-1){1'b0}}, pin};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic hold_level(logic pin, int n);
    repeat (n) send_beat(KIND_TICK, pin);
  endtask

  // Leaves cfg_valid high between writes; the caller drops it once.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [31:0] deb, logic [31:0] smax, logic [31:0] lmin,
                               logic [31:0] cyc, logic btn, logic rly);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_SHORT_MAX, smax);
    write_reg(REG_LONG_MIN, lmin);
    write_reg(REG_CYCLE, cyc);
    write_reg(REG_BTN_LEVEL, {31'd0, btn});
    write_reg(REG_RELAY_LVL, {31'd0, rly});
    cfg_valid <= 1'b0;
    set_deb  = deb[15:0];
    set_smax = smax;
    set_lmin = lmin;
    set_btn  = btn;
  endtask

  // Stop the input stream, wait for every owed status beat, then let the
  // pipeline settle before registers change.
  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (in_flight != 0 && waited < 5000);
    if (in_flight != 0) leftover = 1'b1;
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed presses of random length around the thresholds, with
  // commands, stray samples and bounces mixed in.
  task automatic run_phase(int n);
    int     stop_at;
    int     r;
    int     lim;
    int     deb_eff;
    longint top_thr;
    stop_at = beats_sent + n;
    // Keep presses short even when the debounce wait is huge: the wait then
    // simply never completes.
    deb_eff = (set_deb > 8) ? 8 : int'(set_deb);
    top_thr = (set_smax > set_lmin) ? longint'(set_smax) : longint'(set_lmin);
    lim     = (top_thr + 3 > 45) ? 45 : int'(top_thr + 3);
    while (beats_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_beat(kind_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
      end else if (r < 25) begin
        send_beat(KIND_TICK, 1'($urandom_range(0, 1)));
      end else begin
        // Bounce: one pressed sample, one released, dropped as noise.
        if ($urandom_range(0, 4) == 0) begin
          send_beat(KIND_TICK, set_btn);
          send_beat(KIND_TICK, ~set_btn);
        end
        hold_level(set_btn, deb_eff + 1 + $urandom_range(0, lim));
        if ($urandom_range(0, 5) == 0)
          send_beat(kind_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
        hold_level(~set_btn, deb_eff + 1 + $urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: short thresholds, active-low button, active-high relay.
    apply_setting(2, 6, 12, 20, 1'b0, 1'b1);
    send_beat(KIND_ADD, 1'b1);   // idle to timed
    send_beat(KIND_ADD, 1'b0);   // extend the countdown
    send_beat(KIND_ON, 1'b0);    // permanent, count cleared
    send_beat(KIND_ADD, 1'b1);   // ignored while permanent
    send_beat(KIND_OFF, 1'b1);   // back to idle
    send_beat(KIND_ADD, 1'b0);
    hold_level(1'b0, 4);         // press confirmed after the wait
    hold_level(1'b1, 3);         // short release gives a start
    send_beat(KIND_TICK, 1'b0);  // glitch: pending level not held
    hold_level(1'b1, 2);
    send_beat(KIND_ON, 1'b1);
    hold_level(1'b0, 3);
    hold_level(1'b1, 3);         // start while permanent changes nothing
    send_beat(KIND_OFF, 1'b0);
    drain();

    // Flip the button level: the stable level is kept, so the first
    // confirmed release comes without a recorded press.
    apply_setting(0, 5, 10, 15, 1'b1, 1'b0);
    run_phase(270);
    drain();

    // Zero thresholds and a zero cycle: no start, every press a stop, and
    // add time leaves a timer that expires on the next tick.
    apply_setting(3, 0, 0, 0, 1'b0, 1'b1);
    run_phase(270);
    drain();

    // Everything at its maximum: the debounce never completes and the
    // countdown saturates.
    apply_setting(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    run_phase(150);
    drain();

    // Overlapping thresholds: start wins where both apply.
    apply_setting(1, 20, 8, 7, 1'b0, 1'b0);
    run_phase(270);
    drain();

    repeat (2) begin
      apply_setting($urandom_range(0, 6), $urandom_range(0, 30), $urandom_range(0, 40),
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 50),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_phase(270);
      drain();
    end

    // Last part at full rate, cycle near the top to hit saturation.
    stall_en <= 1'b0;
    apply_setting(4, 10, 25, 32'hFFFF_FFF0, 1'b1, 1'b1);
    run_phase(270);
    drain();

    if (error_count == 0 && !leftover)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- debounced_press_switch_timer_core.f -----
src/dpst_pkg.sv
src/dpst_cfg.sv
src/dpst_button.sv
src/dpst_timer.sv
src/debounced_press_switch_timer_core.sv
src/dpst_checker.sv
test/relay_timer_checker.sv
test/tb_top.sv
